// ===== hdl/handheld_memory_map_bus_core_assert.svh =====
// assertion macros used by the bus core back end (hhmmb_back)
`ifndef HANDHELD_MEMORY_MAP_BUS_CORE_ASSERT_SVH
`define HANDHELD_MEMORY_MAP_BUS_CORE_ASSERT_SVH

// same-cycle implication, quiet during reset
`define HHMMB_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define HHMMB_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== hdl/hhmmb_pkg.sv =====
`default_nettype none

package hhmmb_pkg;

  localparam int BOOT_ROM_BYTES = 256;
  localparam int BOOT_AW        = $clog2(BOOT_ROM_BYTES);
  localparam int CART_AW        = 15;
  localparam int BANK_AW        = 13;
  localparam int SPRITE_AW      = 8;
  localparam int PAGE_AW        = 7;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QUEUE_PW       = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] ADDR_BOOT_END   = 16'h00FF;
  localparam logic [15:0] ADDR_HALF_ROM   = 16'h3FFF;
  localparam logic [15:0] ADDR_CART_END   = 16'h7FFF;
  localparam logic [15:0] ADDR_VRAM_END   = 16'h9FFF;
  localparam logic [15:0] ADDR_CRAM_END   = 16'hBFFF;
  localparam logic [15:0] ADDR_WRAM_END   = 16'hDFFF;
  localparam logic [15:0] ADDR_ECHO_END   = 16'hFDFF;
  localparam logic [15:0] ADDR_SPRITE_END = 16'hFEFF;
  localparam logic [15:0] ADDR_IO_END     = 16'hFF7F;
  localparam logic [15:0] ADDR_HRAM_END   = 16'hFFFE;
  localparam logic [15:0] ADDR_JOYPAD     = 16'hFF00;
  localparam logic [15:0] ADDR_DIV        = 16'hFF04;
  localparam logic [15:0] ADDR_TAC_LO     = 16'hFF06;
  localparam logic [15:0] ADDR_IF         = 16'hFF0F;
  localparam logic [15:0] ADDR_LCDC       = 16'hFF40;
  localparam logic [15:0] ADDR_LCD_WR_END = 16'hFF43;
  localparam logic [15:0] ADDR_LY         = 16'hFF44;
  localparam logic [15:0] ADDR_DMA        = 16'hFF46;
  localparam logic [15:0] ADDR_BGP        = 16'hFF47;
  localparam logic [15:0] ADDR_OBP0       = 16'hFF48;
  localparam logic [15:0] ADDR_WX         = 16'hFF4B;
  localparam logic [15:0] ADDR_IE         = 16'hFFFF;
  localparam logic [15:0] CART_LOAD_LIMIT = 16'h8000;

  typedef enum logic [1:0] {
    ACT_READ      = 2'd0,
    ACT_WRITE     = 2'd1,
    ACT_LOAD_CART = 2'd2,
    ACT_LOAD_BOOT = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    REG_NONE,
    REG_CART,
    REG_VRAM,
    REG_CRAM,
    REG_WRAM,
    REG_SPRITE,
    REG_IO,
    REG_HRAM,
    REG_BOOT
  } region_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] address;
    logic [7:0]  data;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       fault;
  } rsp_t;

  // decoded bus operation handed from front to back
  typedef struct packed {
    region_t              region;
    logic                 wr;
    logic                 fault;
    logic [CART_AW-1:0]   off;
    logic [7:0]           data;
  } op_t;

endpackage

`default_nettype wire

// ===== hdl/hhmmb_front.sv =====
`default_nettype none

module hhmmb_front
  import hhmmb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic cfg_data,
  input  wire req_t req,
  output op_t       op
);

  logic        bootrom_overlay;
  logic [15:0] a;
  logic        ovl_hit;
  logic        io_zero;
  logic        rd_fault;
  logic        wr_fault;
  logic        wr_ignore;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bootrom_overlay <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      bootrom_overlay <= cfg_data;
    end
  end

  assign a       = req.address;
  assign ovl_hit = bootrom_overlay && (a <= ADDR_BOOT_END);
  assign io_zero = (a == ADDR_JOYPAD) || ((a >= ADDR_DIV) && (a <= ADDR_TAC_LO));
  assign rd_fault = (a == ADDR_IF) || ((a >= ADDR_LCDC) && (a <= ADDR_LY)) ||
                    (a == ADDR_IE);
  assign wr_fault = ((a >= ADDR_LCDC) && (a <= ADDR_LCD_WR_END)) || (a == ADDR_BGP);
  assign wr_ignore = io_zero || (a == ADDR_DMA) || ((a >= ADDR_OBP0) && (a <= ADDR_WX));

  // memory region classification, first match wins
  always_comb begin
    op.region = REG_NONE;
    op.wr     = 1'b0;
    op.fault  = 1'b0;
    op.off    = a[CART_AW-1:0];
    op.data   = req.data;
    unique case (action_t'(req.action))
      ACT_READ: begin
        priority if (ovl_hit)            op.region = REG_BOOT;
        else if (a <= ADDR_CART_END)     op.region = REG_CART;
        else if (a <= ADDR_VRAM_END)     op.region = REG_VRAM;
        else if (a <= ADDR_CRAM_END)     op.region = REG_CRAM;
        else if (a <= ADDR_ECHO_END)     op.region = REG_WRAM;
        else if (a <= ADDR_SPRITE_END)   op.region = REG_SPRITE;
        else if (io_zero)                op.region = REG_NONE;
        else if (rd_fault)               op.fault  = 1'b1;
        else if (a <= ADDR_IO_END)       op.region = REG_IO;
        else                             op.region = REG_HRAM;
      end
      ACT_WRITE: begin
        op.wr = 1'b1;
        priority if (ovl_hit)            op.region = REG_NONE;
        else if (a <= ADDR_CART_END)     op.region = REG_CART;
        else if (a <= ADDR_VRAM_END)     op.region = REG_VRAM;
        else if (a <= ADDR_CRAM_END)     op.region = REG_CRAM;
        else if (a <= ADDR_ECHO_END)     op.region = REG_WRAM;
        else if (a <= ADDR_SPRITE_END)   op.region = REG_SPRITE;
        else if (wr_fault)               op.fault  = 1'b1;
        else if (wr_ignore)              op.region = REG_NONE;
        else if (a <= ADDR_IO_END)       op.region = REG_IO;
        else if (a <= ADDR_HRAM_END)     op.region = REG_HRAM;
        else                             op.region = REG_NONE;
      end
      ACT_LOAD_CART: begin
        op.wr = 1'b1;
        if (a < CART_LOAD_LIMIT) op.region = REG_CART;
      end
      ACT_LOAD_BOOT: begin
        op.wr = 1'b1;
        if (a < 16'(BOOT_ROM_BYTES)) op.region = REG_BOOT;
      end
      default: op.region = REG_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/hhmmb_queue.sv =====
`default_nettype none

module hhmmb_queue
  import hhmmb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire op_t  push_op,
  input  wire logic pop,
  output op_t       head_op,
  output logic      nonempty,
  output logic      full
);

  op_t                 entry [QUEUE_DEPTH];
  logic [QUEUE_PW-1:0] wr_ptr;
  logic [QUEUE_PW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] count;

  assign head_op  = entry[rd_ptr];
  assign nonempty = (count != '0);
  assign full     = (count == QUEUE_CW'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      priority if (push && !pop) count <= count + 1'b1;
      else if (pop && !push)     count <= count - 1'b1;
      else                       count <= count;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hhmmb_back.sv =====
`default_nettype none
`include "handheld_memory_map_bus_core_assert.svh"

module hhmmb_back
  import hhmmb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire op_t  head_op,
  input  wire logic nonempty,
  output logic      pop,
  output logic      clearing,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [CART_AW-1:0] clr_addr;

  logic [7:0] cart_mem   [2**CART_AW];
  logic [7:0] vram_mem   [2**BANK_AW];
  logic [7:0] cram_mem   [2**BANK_AW];
  logic [7:0] wram_mem   [2**BANK_AW];
  logic [7:0] sprite_mem [2**SPRITE_AW];
  logic [7:0] io_mem     [2**PAGE_AW];
  logic [7:0] hram_mem   [2**PAGE_AW];
  logic [7:0] boot_mem   [BOOT_ROM_BYTES];

  logic [7:0] cart_q, vram_q, cram_q, wram_q, sprite_q, io_q, hram_q, boot_q;

  logic               rd_go;
  logic               wr_go;
  logic [CART_AW-1:0] waddr;
  logic [7:0]         wdata;
  region_t            r_sel;
  logic               r_fault;

  assign clearing = (state == ST_CLEAR);
  assign pop      = nonempty && !clearing && (!rsp_valid || !rsp_stall);
  assign rd_go    = pop && !head_op.wr;
  assign wr_go    = pop && head_op.wr;
  assign waddr    = clearing ? clr_addr : head_op.off;
  assign wdata    = clearing ? 8'h00 : head_op.data;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_addr == '1) state_next = ST_RUN;
      ST_RUN:   state_next = ST_RUN;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clearing ? clr_addr + 1'b1 : clr_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing || (wr_go && head_op.region == REG_CART)) cart_mem[waddr] <= wdata;
    if (rd_go && head_op.region == REG_CART) cart_q <= cart_mem[head_op.off];
  end

  always_ff @(posedge clk) begin
    if (clearing || (wr_go && head_op.region == REG_VRAM)) begin
      vram_mem[waddr[BANK_AW-1:0]] <= wdata;
    end
    if (rd_go && head_op.region == REG_VRAM) vram_q <= vram_mem[head_op.off[BANK_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (clearing || (wr_go && head_op.region == REG_CRAM)) begin
      cram_mem[waddr[BANK_AW-1:0]] <= wdata;
    end
    if (rd_go && head_op.region == REG_CRAM) cram_q <= cram_mem[head_op.off[BANK_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (clearing || (wr_go && head_op.region == REG_WRAM)) begin
      wram_mem[waddr[BANK_AW-1:0]] <= wdata;
    end
    if (rd_go && head_op.region == REG_WRAM) wram_q <= wram_mem[head_op.off[BANK_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (clearing || (wr_go && head_op.region == REG_SPRITE)) begin
      sprite_mem[waddr[SPRITE_AW-1:0]] <= wdata;
    end
    if (rd_go && head_op.region == REG_SPRITE) begin
      sprite_q <= sprite_mem[head_op.off[SPRITE_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (clearing || (wr_go && head_op.region == REG_IO)) io_mem[waddr[PAGE_AW-1:0]] <= wdata;
    if (rd_go && head_op.region == REG_IO) io_q <= io_mem[head_op.off[PAGE_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (clearing || (wr_go && head_op.region == REG_HRAM)) begin
      hram_mem[waddr[PAGE_AW-1:0]] <= wdata;
    end
    if (rd_go && head_op.region == REG_HRAM) hram_q <= hram_mem[head_op.off[PAGE_AW-1:0]];
  end

  // boot rom is only filled by loads, never swept
  always_ff @(posedge clk) begin
    if (wr_go && head_op.region == REG_BOOT) boot_mem[head_op.off[BOOT_AW-1:0]] <= head_op.data;
    if (rd_go && head_op.region == REG_BOOT) boot_q <= boot_mem[head_op.off[BOOT_AW-1:0]];
  end

  // result stage: remembers which memory answers
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (pop) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      r_sel   <= head_op.wr ? REG_NONE : head_op.region;
      r_fault <= head_op.fault;
    end
  end

  always_comb begin
    rsp.fault = r_fault;
    unique case (r_sel)
      REG_CART:   rsp.read_data = cart_q;
      REG_VRAM:   rsp.read_data = vram_q;
      REG_CRAM:   rsp.read_data = cram_q;
      REG_WRAM:   rsp.read_data = wram_q;
      REG_SPRITE: rsp.read_data = sprite_q;
      REG_IO:     rsp.read_data = io_q;
      REG_HRAM:   rsp.read_data = hram_q;
      REG_BOOT:   rsp.read_data = boot_q;
      REG_NONE:   rsp.read_data = 8'h00;
      default:    rsp.read_data = 8'h00;
    endcase
  end

  `HHMMB_ASSERT_NOW(a_no_pop_in_clear, clearing, !pop, "transaction issued during memory sweep")
  `HHMMB_ASSERT_NEXT(a_pop_gives_rsp, pop, rsp_valid, "issued transaction produced no response")
  `HHMMB_ASSERT_NOW(a_fault_no_region, rsp_valid && r_fault, r_sel == REG_NONE, "fault with memory select")
  `HHMMB_ASSERT_NOW(a_fault_zero, rsp_valid && rsp.fault, rsp.read_data == 8'h00, "fault with nonzero data")

endmodule

`default_nettype wire

// ===== hdl/handheld_memory_map_bus_core.sv =====
// an accepted transaction is queued, then issued from the queue head into the registered response
// throughput: one transaction per cycle while rsp_stall is low and no memory sweep is running
// reset: after rst the back end sweeps zeros through every store (the 32K cartridge rom sets the
// length), req_stall stays high meanwhile; boot rom is not swept
// reset also turns the boot rom overlay on; the config port is always ready
`default_nettype none

module handheld_memory_map_bus_core
  import hhmmb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  // request channel
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  // response channel
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp,
  // overlay config write
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic cfg_data
);

  op_t  dec_op;     // classified request from the front end
  op_t  head_op;    // oldest queued operation
  logic q_nonempty;
  logic q_full;
  logic q_pop;
  logic clearing;
  logic push;

  // stall only on registered conditions: queue full or memory sweep running
  assign req_stall = q_full || clearing;
  assign push      = req_valid && !req_stall;

  // front end: overlay register and address decode
  hhmmb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .req       (req),
    .op        (dec_op)
  );

  // short queue decouples decode from memory access
  hhmmb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_op  (dec_op),
    .pop      (q_pop),
    .head_op  (head_op),
    .nonempty (q_nonempty),
    .full     (q_full)
  );

  // back end: stores, reset sweep and response register
  hhmmb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_op   (head_op),
    .nonempty  (q_nonempty),
    .pop       (q_pop),
    .clearing  (clearing),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire
